// File: sv/ip_prefix_tree_lookup_assert.svh
// ----------------------------------------------------------------------------
// ip_prefix_tree_lookup_assert.svh
// Assertion macros for the prefix tree lookup. They expand to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef IP_PREFIX_TREE_LOOKUP_ASSERT_SVH
`define IP_PREFIX_TREE_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// ante must be followed by cons in the same cycle
`define IPPTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ipptl assertion failed");
// expr must never hold
`define IPPTL_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("ipptl assertion failed");
`else
`define IPPTL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IPPTL_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: sv/ipptl_pkg.sv
// ----------------------------------------------------------------------------
// ipptl_pkg
// Shared types and constants of the prefix tree lookup.
// ----------------------------------------------------------------------------
package ipptl_pkg;

	// default tree store size in bytes
	localparam int TREE_BYTES_DEF = 65536;

	// command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// store is split in byte lanes so one record comes out in one read
	localparam int LANES  = 4;
	localparam int LANE_W = 2;

	// base byte position of a record
	localparam int BASE_W = 21;

	// result status codes
	localparam logic [2:0] STAT_WRITE   = 3'd0;
	localparam logic [2:0] STAT_HIT     = 3'd1;
	localparam logic [2:0] STAT_NONE    = 3'd2;
	localparam logic [2:0] STAT_REJECT  = 3'd3;
	localparam logic [2:0] STAT_OUTSIDE = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_NODE_COUNT    = 2'd0;
	localparam logic [1:0] CFG_RECORD_FORMAT = 2'd1;
	localparam logic [1:0] CFG_TREE_IS_IPV6  = 2'd2;

	// record formats; the unused code decodes as 32-bit records
	localparam logic [1:0] FMT_24 = 2'd0;
	localparam logic [1:0] FMT_28 = 2'd1;

	// walk depths
	localparam logic [7:0] LAST_BIT_V4 = 8'd31;
	localparam logic [7:0] LAST_BIT_V6 = 8'd127;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_REJECT = 2'd1,
		CMD_WALK   = 2'd2
	} cmd_kind_t;

	// classified request as it travels through the queue
	typedef struct packed {
		cmd_kind_t      kind;
		logic           wr_ok;
		logic [15:0]    wr_addr;
		logic [7:0]     wr_data;
		logic [127:0]   key;
		logic           long_walk;
	} cmd_t;

endpackage

// File: sv/ipptl_ram.sv
// ----------------------------------------------------------------------------
// ipptl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ipptl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/ipptl_front.sv
// ----------------------------------------------------------------------------
// ipptl_front
// Classifies a request into a store write, a rejection or a tree walk and
// builds the 128-bit walk key, most significant bit walked first.
// ----------------------------------------------------------------------------
module ipptl_front #(
	parameter int TREE_BYTES = ipptl_pkg::TREE_BYTES_DEF
) (
	input  logic               action,
	input  logic [15:0]        byte_address,
	input  logic [7:0]         byte_value,
	input  logic [63:0]        key_high,
	input  logic [63:0]        key_low,
	input  logic               key_is_v4,
	input  logic [15:0]        node_total,
	input  logic               tree_is_ipv6,
	output ipptl_pkg::cmd_t    cmd
);

	always_comb begin
		cmd.wr_addr   = byte_address;
		cmd.wr_data   = byte_value;
		// writes past the store end are dropped but still answered
		cmd.wr_ok     = 32'(byte_address) < 32'(TREE_BYTES);
		cmd.long_walk = tree_is_ipv6;

		// key placement: v4 tree uses the top 32 bits, v4 in v6 sits after 96 zeros
		if (!tree_is_ipv6) begin
			cmd.key = {key_low[31:0], 96'd0};
		end else if (key_is_v4) begin
			cmd.key = {96'd0, key_low[31:0]};
		end else begin
			cmd.key = {key_high, key_low};
		end

		if (!action) begin
			cmd.kind = ipptl_pkg::CMD_WRITE;
		end else if (node_total == 16'd0 || (!tree_is_ipv6 && !key_is_v4)) begin
			cmd.kind = ipptl_pkg::CMD_REJECT;
		end else begin
			cmd.kind = ipptl_pkg::CMD_WALK;
		end
	end

endmodule

// File: sv/ipptl_queue.sv
// ----------------------------------------------------------------------------
// ipptl_queue
// Short command FIFO that lets the front accept while the back walks.
// ----------------------------------------------------------------------------
module ipptl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ipptl_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output ipptl_pkg::cmd_t head
);

	ipptl_pkg::cmd_t                   entry_q [ipptl_pkg::QUEUE_DEPTH];
	logic [ipptl_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ipptl_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ipptl_pkg::QCNT_W-1:0]      count_q;

	assign full  = count_q == ipptl_pkg::QCNT_W'(ipptl_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: sv/ipptl_back.sv
// ----------------------------------------------------------------------------
// ipptl_back
// Executes queued commands: byte writes into the lane-split tree store and
// the tree walk, one record read and one record check per level.
// ----------------------------------------------------------------------------
module ipptl_back #(
	parameter int TREE_BYTES = ipptl_pkg::TREE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  ipptl_pkg::cmd_t cmd,
	output logic            cmd_pop,
	input  logic [15:0]     node_total,
	input  logic [1:0]      record_format,
	output logic            done,
	output logic [2:0]      status,
	output logic [31:0]     data_offset,
	output logic [7:0]      bits_walked
);

	localparam int BANK_DEPTH = (TREE_BYTES + ipptl_pkg::LANES - 1) / ipptl_pkg::LANES;
	localparam int ROW_W      = $clog2(BANK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ADDR = 3'b010,
		S_EVAL = 3'b100
	} state_t;

	state_t                         state_q, state_d;
	logic                           done_q;
	logic [2:0]                     status_q;
	logic [31:0]                    offset_q;
	logic [7:0]                     walked_q;
	logic [15:0]                    node_q;
	logic [7:0]                     level_q;
	logic [127:0]                   key_q;
	logic                           long_q;
	logic [ipptl_pkg::LANE_W-1:0]   lane_q;

	logic                           side;
	logic [ipptl_pkg::BASE_W-1:0]   node_x;
	logic [ipptl_pkg::BASE_W-1:0]   base;
	logic [2:0]                     rec_len;
	logic [31:0]                    end_pos;
	logic                           outside;
	logic [31:0]                    wr_pos;
	logic [ROW_W-1:0]               rd_row [ipptl_pkg::LANES];
	logic                           bank_we [ipptl_pkg::LANES];
	logic [7:0]                     bank_rdata [ipptl_pkg::LANES];
	logic [7:0]                     rb [ipptl_pkg::LANES];
	logic [31:0]                    rec;
	logic [31:0]                    nc32;
	logic [7:0]                     last_bit;
	logic                           emit, load, adv;
	logic [2:0]                     e_status;
	logic [31:0]                    e_offset;
	logic [7:0]                     e_walked;

	assign side     = key_q[127];
	assign node_x   = ipptl_pkg::BASE_W'(node_q);
	assign nc32     = 32'(node_total);
	assign last_bit = long_q ? ipptl_pkg::LAST_BIT_V6 : ipptl_pkg::LAST_BIT_V4;
	assign wr_pos   = 32'(cmd.wr_addr);
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;

	// record base position and length
	always_comb begin
		case (record_format)
			ipptl_pkg::FMT_24: begin
				base    = node_x * ipptl_pkg::BASE_W'(6) + (side ? ipptl_pkg::BASE_W'(3) : '0);
				rec_len = 3'd3;
			end
			ipptl_pkg::FMT_28: begin
				base    = node_x * ipptl_pkg::BASE_W'(7) + (side ? ipptl_pkg::BASE_W'(3) : '0);
				rec_len = 3'd4;
			end
			default: begin
				base    = {node_x[ipptl_pkg::BASE_W-4:0], 3'd0} +
					(side ? ipptl_pkg::BASE_W'(4) : '0);
				rec_len = 3'd4;
			end
		endcase
		end_pos = 32'(base) + 32'(rec_len);
		outside = end_pos > 32'(TREE_BYTES);
	end

	// per-lane row of the record bytes, lane k of the record sits at base+k
	always_comb begin
		logic [ipptl_pkg::LANE_W-1:0] k;
		logic [31:0]                  pos;
		for (int b = 0; b < ipptl_pkg::LANES; b++) begin
			k         = ipptl_pkg::LANE_W'(b) - base[ipptl_pkg::LANE_W-1:0];
			pos       = 32'(base) + 32'(k);
			rd_row[b] = pos[ROW_W+1:2];
			bank_we[b] = cmd_pop && cmd.kind == ipptl_pkg::CMD_WRITE && cmd.wr_ok &&
				wr_pos[ipptl_pkg::LANE_W-1:0] == ipptl_pkg::LANE_W'(b);
		end
	end

	// tree store, one byte lane per bank
	for (genvar g = 0; g < ipptl_pkg::LANES; g++) begin : g_bank
		ipptl_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[g]),
			.waddr (wr_pos[ROW_W+1:2]),
			.wdata (cmd.wr_data),
			.raddr (rd_row[g]),
			.rdata (bank_rdata[g])
		);
	end

	// rotate lanes back into record byte order and decode the record
	always_comb begin
		for (int k = 0; k < ipptl_pkg::LANES; k++) begin
			rb[k] = bank_rdata[ipptl_pkg::LANE_W'(lane_q + ipptl_pkg::LANE_W'(k))];
		end
		case (record_format)
			ipptl_pkg::FMT_24: rec = {8'd0, rb[0], rb[1], rb[2]};
			ipptl_pkg::FMT_28: begin
				if (side) begin
					rec = {4'd0, rb[0][3:0], rb[1], rb[2], rb[3]};
				end else begin
					rec = {4'd0, rb[3][7:4], rb[0], rb[1], rb[2]};
				end
			end
			default: rec = {rb[0], rb[1], rb[2], rb[3]};
		endcase
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		load     = 1'b0;
		adv      = 1'b0;
		e_status = ipptl_pkg::STAT_NONE;
		e_offset = '0;
		e_walked = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						ipptl_pkg::CMD_WRITE: begin
							emit     = 1'b1;
							e_status = ipptl_pkg::STAT_WRITE;
						end
						ipptl_pkg::CMD_REJECT: begin
							emit     = 1'b1;
							e_status = ipptl_pkg::STAT_REJECT;
						end
						ipptl_pkg::CMD_WALK: begin
							load    = 1'b1;
							state_d = S_ADDR;
						end
						default: begin
							emit     = 1'b1;
							e_status = ipptl_pkg::STAT_REJECT;
						end
					endcase
				end
			end
			S_ADDR: begin
				if (outside) begin
					emit     = 1'b1;
					e_status = ipptl_pkg::STAT_OUTSIDE;
					e_walked = level_q;
					state_d  = S_IDLE;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				e_walked = level_q + 8'd1;
				if (rec == nc32) begin
					emit     = 1'b1;
					e_status = ipptl_pkg::STAT_NONE;
					state_d  = S_IDLE;
				end else if (rec > nc32) begin
					emit     = 1'b1;
					e_status = ipptl_pkg::STAT_HIT;
					e_offset = rec - nc32;
					state_d  = S_IDLE;
				end else if (level_q == last_bit) begin
					// every key bit used, still pointing at a node
					emit     = 1'b1;
					e_status = ipptl_pkg::STAT_NONE;
					state_d  = S_IDLE;
				end else begin
					adv     = 1'b1;
					state_d = S_ADDR;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= cmd.key;
			long_q  <= cmd.long_walk;
			node_q  <= '0;
			level_q <= '0;
		end
		if (adv) begin
			key_q   <= {key_q[126:0], 1'b0};
			node_q  <= rec[15:0];
			level_q <= level_q + 8'd1;
		end
		if (state_q == S_ADDR) begin
			lane_q <= base[ipptl_pkg::LANE_W-1:0];
		end
		if (emit) begin
			status_q <= e_status;
			offset_q <= e_offset;
			walked_q <= e_walked;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign data_offset = offset_q;
	assign bits_walked = walked_q;

endmodule

// File: sv/ip_prefix_tree_lookup.sv
// ----------------------------------------------------------------------------
// ip_prefix_tree_lookup
// Binary prefix tree lookup over a byte store: byte loads and address walks.
//
//  channel   handshake            payload
//  request   start / busy         action, byte_address, byte_value,
//                                 key_high, key_low, key_is_v4
//  result    done (1-cycle)       status, data_offset, bits_walked
//  config    cfg_write            cfg_index, cfg_data
//
// A write or rejected request is answered straight from the idle state; a
// lookup that reads L records (L up to 32 or 128) alternates an address state
// and a check state per level, and stops early at a record outside the store:
// each level is one registered read of the four store lanes and one record
// check. Results are registered once decided and come out in request order.
// busy is high while the two-entry command queue is full. Reset empties the
// queue and loads a node total of 0, record_format 0, tree_is_ipv6 1; the
// tree store is not cleared.
// ----------------------------------------------------------------------------
`include "ip_prefix_tree_lookup_assert.svh"

module ip_prefix_tree_lookup #(
	parameter int TREE_BYTES = ipptl_pkg::TREE_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic         action,
	input  logic [15:0]  byte_address,
	input  logic [7:0]   byte_value,
	input  logic [63:0]  key_high,
	input  logic [63:0]  key_low,
	input  logic         key_is_v4,
	output logic         done,
	output logic [2:0]   status,
	output logic [31:0]  data_offset,
	output logic [7:0]   bits_walked,
	input  logic         cfg_write,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [15:0]     node_total_q;
	logic [1:0]      record_format_q;
	logic            tree_is_ipv6_q;
	ipptl_pkg::cmd_t front_cmd;
	ipptl_pkg::cmd_t head_cmd;
	logic            q_full, q_empty, q_pop, q_push;
	logic            hit_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_total_q    <= '0;
			record_format_q <= ipptl_pkg::FMT_24;
			tree_is_ipv6_q  <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				ipptl_pkg::CFG_NODE_COUNT:    node_total_q    <= cfg_data;
				ipptl_pkg::CFG_RECORD_FORMAT: record_format_q <= cfg_data[1:0];
				ipptl_pkg::CFG_TREE_IS_IPV6:  tree_is_ipv6_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy   = q_full;
	assign q_push = start && !q_full;

	// request classification
	ipptl_front #(
		.TREE_BYTES(TREE_BYTES)
	) u_front (
		.action       (action),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.key_high     (key_high),
		.key_low      (key_low),
		.key_is_v4    (key_is_v4),
		.node_total   (node_total_q),
		.tree_is_ipv6 (tree_is_ipv6_q),
		.cmd          (front_cmd)
	);

	// command queue
	ipptl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_cmd)
	);

	// execution: store writes and tree walks
	ipptl_back #(
		.TREE_BYTES(TREE_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (!q_empty),
		.cmd           (head_cmd),
		.cmd_pop       (q_pop),
		.node_total    (node_total_q),
		.record_format (record_format_q),
		.done          (done),
		.status        (status),
		.data_offset   (data_offset),
		.bits_walked   (bits_walked)
	);

	// checks
	assign hit_out = done && status == ipptl_pkg::STAT_HIT;

	`IPPTL_ASSERT_IMP(a_busy_after_request, clk, arst_n, $rose(busy), $past(start))
	`IPPTL_ASSERT_IMP(a_hit_has_bits, clk, arst_n, hit_out, bits_walked != 8'd0)
	`IPPTL_ASSERT_IMP(a_offset_only_on_hit, clk, arst_n, done && !hit_out, data_offset == 32'd0)
	`IPPTL_ASSERT_NEVER(a_walk_bound, clk, arst_n, done && bits_walked > 8'd128)

endmodule

// File: bench/ipptl_lookup_checker.sv
// ----------------------------------------------------------------------------
// ipptl_lookup_checker
// Scoreboard for the prefix tree lookup. It watches the request, result and
// config ports, keeps its own copy of the tree store and registers, works
// out the outcome of every accepted request and compares each result
// strobe with the oldest outstanding outcome.
// ----------------------------------------------------------------------------
package ipptl_tb_pkg;

	// request action codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// record formats the design package leaves unnamed
	localparam logic [1:0] FMT_32    = 2'd2;
	localparam logic [1:0] FMT_SPARE = 2'd3;

endpackage

module ipptl_lookup_checker #(
	parameter int TREE_BYTES = ipptl_pkg::TREE_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         busy,
	input  logic         action,
	input  logic [15:0]  byte_address,
	input  logic [7:0]   byte_value,
	input  logic [63:0]  key_high,
	input  logic [63:0]  key_low,
	input  logic         key_is_v4,
	input  logic         done,
	input  logic [2:0]   status,
	input  logic [31:0]  data_offset,
	input  logic [7:0]   bits_walked,
	input  logic         cfg_write,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output int           pending,
	output int           fails
);
	import ipptl_pkg::*;
	import ipptl_tb_pkg::*;

	localparam int WALK_V4 = 32;
	localparam int WALK_V6 = 128;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] offset;
		logic [7:0]  walked;
	} outcome_t;

	// shadow of the tree store and the config registers
	logic [7:0]  tree_mem [TREE_BYTES];
	logic [15:0] count_q;
	logic [1:0]  fmt_q;
	logic        v6_q;

	outcome_t    outstanding [$];
	outcome_t    want;

	// one record of a node; 0 when any byte of it lies past the store
	function automatic bit fetch_record(input int node, input logic side,
			output logic [31:0] rec);
		int base;
		rec = '0;
		case (fmt_q)
			FMT_24: begin
				base = node * 6 + (side ? 3 : 0);
				if (base + 3 > TREE_BYTES)
					return 1'b0;
				rec = {8'h00, tree_mem[base], tree_mem[base + 1], tree_mem[base + 2]};
			end
			FMT_28: begin
				base = node * 7;
				if (!side) begin
					if (base + 4 > TREE_BYTES)
						return 1'b0;
					rec = {4'h0, tree_mem[base + 3][7:4], tree_mem[base],
						tree_mem[base + 1], tree_mem[base + 2]};
				end else begin
					if (base + 7 > TREE_BYTES)
						return 1'b0;
					rec = {4'h0, tree_mem[base + 3][3:0], tree_mem[base + 4],
						tree_mem[base + 5], tree_mem[base + 6]};
				end
			end
			default: begin
				// 32-bit records, spare code included
				base = node * 8 + (side ? 4 : 0);
				if (base + 4 > TREE_BYTES)
					return 1'b0;
				rec = {tree_mem[base], tree_mem[base + 1], tree_mem[base + 2],
					tree_mem[base + 3]};
			end
		endcase
		return 1'b1;
	endfunction

	// walk from node 0 along the key, msb first
	function automatic outcome_t walk_tree(input logic [63:0] kh, input logic [63:0] kl,
			input logic v4);
		outcome_t    r;
		logic [127:0] path;
		logic [31:0] rec;
		int          node;
		int          depth;
		r = '0;
		r.status = STAT_NONE;
		if (count_q == 0 || (!v6_q && !v4)) begin
			r.status = STAT_REJECT;
			return r;
		end
		depth = v6_q ? WALK_V6 : WALK_V4;
		// IPv4 keys sit after 96 zero bits on an IPv6 tree
		if (!v6_q)
			path = {kl[31:0], 96'h0};
		else if (v4)
			path = {96'h0, kl[31:0]};
		else
			path = {kh, kl};
		node = 0;
		for (int i = 0; i < depth; i++) begin
			if (!fetch_record(node, path[127 - i], rec)) begin
				r.status = STAT_OUTSIDE;
				r.walked = 8'(i);
				return r;
			end
			r.walked = 8'(i + 1);
			if (rec == count_q) begin
				r.status = STAT_NONE;
				return r;
			end
			if (rec > count_q) begin
				r.status = STAT_HIT;
				r.offset = rec - count_q;
				return r;
			end
			node = int'(rec);
		end
		// every bit used and still on a node: no entry
		return r;
	endfunction

	// result compare first, then config and request capture
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q = '0;
			fmt_q   = FMT_24;
			v6_q    = 1'b1;
			outstanding.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (outstanding.size() == 0) begin
					$error("result with no request outstanding: status %0d", status);
					fails = fails + 1;
				end else begin
					want = outstanding.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fails = fails + 1;
					end
					if (data_offset !== want.offset) begin
						$error("data_offset: expected %0h, actual %0h",
							want.offset, data_offset);
						fails = fails + 1;
					end
					if (bits_walked !== want.walked) begin
						$error("bits_walked: expected %0d, actual %0d",
							want.walked, bits_walked);
						fails = fails + 1;
					end
				end
			end

			if (cfg_write) begin
				case (cfg_index)
					CFG_NODE_COUNT:    count_q = cfg_data;
					CFG_RECORD_FORMAT: fmt_q   = cfg_data[1:0];
					CFG_TREE_IS_IPV6:  v6_q    = cfg_data[0];
					default: ;
				endcase
			end

			if (start && !busy) begin
				if (action == ACT_WRITE) begin
					tree_mem[byte_address] = byte_value;
					want = '0;
					want.status = STAT_WRITE;
					outstanding.push_back(want);
				end else begin
					outstanding.push_back(walk_tree(key_high, key_low, key_is_v4));
				end
			end
			pending <= outstanding.size();
		end
	end

endmodule

// File: bench/tb_ip_prefix_tree_lookup.sv
// ----------------------------------------------------------------------------
// tb_ip_prefix_tree_lookup
// Stimulus and verdict for the prefix tree lookup. Each phase programs the
// registers while the block is idle, loads a small random tree through byte
// writes (links reach nodes it wrote or ones past the store end) and probes it
// with random and extreme keys. Results are checked by ipptl_lookup_checker.
// ----------------------------------------------------------------------------
module tb_ip_prefix_tree_lookup;
	import ipptl_pkg::*;
	import ipptl_tb_pkg::*;

	localparam int STORE_BYTES  = TREE_BYTES_DEF;
	localparam int ITEM_TARGET  = 1450;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 300;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic         action;
	logic [15:0]  byte_address;
	logic [7:0]   byte_value;
	logic [63:0]  key_high;
	logic [63:0]  key_low;
	logic         key_is_v4;
	logic         done;
	logic [2:0]   status;
	logic [31:0]  data_offset;
	logic [7:0]   bits_walked;
	logic         cfg_write;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;

	int           pending;
	int           fails;

	// what the current phase has programmed and built
	int           n_nodes;
	logic [1:0]   rec_fmt;
	logic         tree_v6;
	int           tree_nodes [$];
	int           sent;
	bit           steady;
	logic [1:0]   fmt_cycle [4] = '{FMT_24, FMT_28, FMT_32, FMT_SPARE};

	ip_prefix_tree_lookup DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.key_high     (key_high),
		.key_low      (key_low),
		.key_is_v4    (key_is_v4),
		.done         (done),
		.status       (status),
		.data_offset  (data_offset),
		.bits_walked  (bits_walked),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ipptl_lookup_checker #(.TREE_BYTES(STORE_BYTES)) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.key_high     (key_high),
		.key_low      (key_low),
		.key_is_v4    (key_is_v4),
		.done         (done),
		.status       (status),
		.data_offset  (data_offset),
		.bits_walked  (bits_walked),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.fails        (fails)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: cycles with neither a request taken nor a result out
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// one request; start stays high across back-to-back requests
	task automatic issue(input logic act, input logic [15:0] addr, input logic [7:0] val,
			input logic [63:0] kh, input logic [63:0] kl, input logic v4);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		action       <= act;
		byte_address <= addr;
		byte_value   <= val;
		key_high     <= kh;
		key_low      <= kl;
		key_is_v4    <= v4;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	task automatic put_byte(input logic [15:0] addr, input logic [7:0] val);
		issue(ACT_WRITE, addr, val, {$urandom, $urandom}, {$urandom, $urandom},
			1'($urandom));
	endtask

	task automatic look_up(input logic [63:0] kh, input logic [63:0] kl, input logic v4);
		issue(ACT_LOOKUP, 16'($urandom), 8'($urandom), kh, kl, v4);
	endtask

	// hold requests off until every outstanding result has come back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic load_config(input int n, input logic [1:0] fmt, input logic v6);
		settle();
		n_nodes = n;
		rec_fmt = fmt;
		tree_v6 = v6;
		cfg_write <= 1'b1;
		cfg_index <= CFG_NODE_COUNT;
		cfg_data  <= 16'(n);
		@(posedge clk);
		cfg_index <= CFG_RECORD_FORMAT;
		cfg_data  <= {14'($urandom), fmt};
		@(posedge clk);
		cfg_index <= CFG_TREE_IS_IPV6;
		cfg_data  <= {15'($urandom), v6};
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// write both records of a node in the current format; bytes past the
	// store end are dropped
	task automatic put_node(input int node, input logic [31:0] lrec, input logic [31:0] rrec);
		logic [63:0] img;
		int          len;
		int          base;
		case (rec_fmt)
			FMT_24: begin
				img = {lrec[23:0], rrec[23:0], 16'h0};
				len = 6;
			end
			FMT_28: begin
				img = {lrec[23:0], lrec[27:24], rrec[27:24], rrec[23:0], 8'h0};
				len = 7;
			end
			default: begin
				img = {lrec, rrec};
				len = 8;
			end
		endcase
		base = node * len;
		for (int k = 0; k < len; k++)
			if (base + k < STORE_BYTES)
				put_byte(16'(base + k), img[63 - 8 * k -: 8]);
	endtask

	// child record: mostly a node of this tree, else a terminal or a node past the store end
	function automatic logic [31:0] pick_record(input int reach_pct, input int fit,
			input logic [31:0] rec_max);
		longint unsigned room;
		if ($urandom_range(0, 99) < reach_pct)
			return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
		room = rec_max - n_nodes;
		case ($urandom_range(0, 4))
			0: return n_nodes + 1;
			1: return rec_max;
			2: return 32'(n_nodes + 1 + ({$urandom, $urandom} % room));
			3: begin
				// a node whose records lie past the store end
				if (n_nodes > fit + 1)
					return $urandom_range(fit + 1, n_nodes - 1);
				return n_nodes;
			end
			default: return n_nodes;
		endcase
	endfunction

	task automatic build_tree();
		int          len;
		int          fit;
		int          span;
		int          reach_pct;
		logic [31:0] rec_max;
		tree_nodes.delete();
		if (n_nodes == 0)
			return;
		len = (rec_fmt == FMT_24) ? 6 : (rec_fmt == FMT_28) ? 7 : 8;
		rec_max = (rec_fmt == FMT_24) ? 32'h00FF_FFFF :
			(rec_fmt == FMT_28) ? 32'h0FFF_FFFF : 32'hFFFF_FFFF;
		fit = STORE_BYTES / len;
		// readable nodes, plus the first node that reaches past the store end
		span = (n_nodes < fit + 1) ? n_nodes : fit + 1;
		reach_pct = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(55, 95);
		tree_nodes.push_back(0);
		if (span > 1) begin
			repeat ($urandom_range(0, 9)) begin
				if ($urandom_range(0, 3) == 0)
					tree_nodes.push_back(span - 1);
				else
					tree_nodes.push_back($urandom_range(1, span - 1));
			end
		end
		for (int j = 0; j < tree_nodes.size(); j++)
			put_node(tree_nodes[j], pick_record(reach_pct, fit, rec_max),
				pick_record(reach_pct, fit, rec_max));
	endtask

	task automatic probe_tree(input int count);
		logic [63:0] kh;
		logic [63:0] kl;
		logic        v4;
		repeat (count) begin
			kh = {$urandom, $urandom};
			kl = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: begin
					kh = '0;
					kl = '0;
				end
				1: begin
					kh = '1;
					kl = '1;
				end
				2: kl[31:0] = '0;
				default: ;
			endcase
			v4 = tree_v6 ? 1'($urandom) : ($urandom_range(0, 9) != 0);
			look_up(kh, kl, v4);
		end
	endtask

	initial begin
		int n;
		int phase;
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_WRITE;
		byte_address = '0;
		byte_value   = '0;
		key_high     = '0;
		key_low      = '0;
		key_is_v4    = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = CFG_NODE_COUNT;
		cfg_data     = '0;
		sent         = 0;
		steady       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tree after reset: both key kinds are rejected
		look_up('1, '1, 1'b0);
		look_up('0, 64'h0000_0000_0A00_0001, 1'b1);

		// one-node IPv4 tree, 24-bit records: left no entry, right top hit
		load_config(1, FMT_24, 1'b0);
		put_node(0, 32'd1, 32'h00FF_FFFF);
		look_up('0, '0, 1'b1);
		look_up('0, 64'hFFFF_FFFF_8000_0000, 1'b1);
		look_up('1, '1, 1'b0);

		// spare format code on a full-size IPv6 tree: node 0 loops on its
		// left and points past the store end on its right
		load_config(16'hFFFF, FMT_SPARE, 1'b1);
		put_node(0, 32'd0, 32'd9000);
		look_up('0, '0, 1'b0);
		look_up(64'h8000_0000_0000_0000, '0, 1'b0);
		look_up('1, 64'h0000_0000_8000_0000, 1'b1);

		// random phases
		phase = 0;
		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 7))
				0: n = 0;
				1: n = 1;
				2: n = 16'hFFFF;
				3, 4: n = $urandom_range(2, 40);
				5: n = $urandom_range(8000, 11000);
				default: n = $urandom_range(1, 65535);
			endcase
			load_config(n, (phase < 4) ? fmt_cycle[phase] : fmt_cycle[$urandom_range(0, 3)],
				1'($urandom));
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(0, 6))
				put_byte(16'($urandom), 8'($urandom));
			build_tree();
			probe_tree($urandom_range(30, 70));
			phase++;
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
